### rtl/awm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types and constants of the anagram window matcher: default sizes,
// item codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
package awm_pkg;

	localparam int              AWM_MAX_PATTERN = 32;
	localparam longint unsigned AWM_MAX_TEXT    = 64'd65536;
	localparam int              AWM_ALPHABET    = 26;

	localparam int MODE_W   = 2;
	localparam int LETTER_W = 5;
	localparam int START_W  = 16;
	localparam int CNT_W    = 6;
	localparam int LIM_W    = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_PATTERN = 2'd0,
		MODE_TEXT    = 2'd1,
		MODE_CLEAR   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [LETTER_W-1:0] letter;
	} item_t;

	typedef struct packed {
		logic [START_W-1:0] match_start;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [START_W-1:0] match_start;
	} core_res_t;

endpackage
`default_nettype wire

### rtl/awm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_if
// Valid/ready channels of the matcher: letter items in, match results out.
// ----------------------------------------------------------------------------
interface awm_item_if import awm_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface awm_result_if import awm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/anagram_window_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anagram_window_matcher_unit
// Streaming search for non-overlapping anagrams of a loaded pattern.
// ----------------------------------------------------------------------------
// Takes one item per clock: pattern letters build the pattern histogram, text
// letters slide a window over the text, and a clear item returns everything to
// its reset state. A match gives one transfer on the result channel carrying
// the text position of the window's first letter (low 16 bits). An item is
// registered on transfer in the input register and worked on once the result
// register can advance, where its result is registered in the result register
// and offered on the result channel. The rate is set by the update of the
// per-letter counters and their compare against the pattern; a result held by
// the sink stalls the input only once the input register is also occupied. The
// window's letters live in a ring memory of the next power of two at or above
// MAX_PATTERN (at least two slots), read ahead at the next oldest slot; it needs
// no clearing after reset, so the block is ready right away.
// ----------------------------------------------------------------------------
module anagram_window_matcher_unit import awm_pkg::*; #(
	parameter int              MAX_PATTERN = AWM_MAX_PATTERN,
	parameter longint unsigned MAX_TEXT    = AWM_MAX_TEXT,
	parameter int              ALPHABET    = AWM_ALPHABET
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	awm_item_if.sink      item,
	awm_result_if.source  result
);

	logic               valid_s1;
	item_t              item_s1;
	logic               adv;
	logic               go;
	core_res_t          core_res;
	logic               res_valid_q;
	logic [START_W-1:0] res_start_q;

	assign adv        = !res_valid_q || result.ready;
	assign go         = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	awm_core #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT),
		.ALPHABET    (ALPHABET)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= core_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res.valid) begin
			res_start_q <= core_res.match_start;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.data.match_start = res_start_q;

	a_res_only_for_item: assert property (@(posedge clk) disable iff (!arst_n)
		core_res.valid |-> go)
		else $error("match reported without an item in flight");

	a_transfer_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted item lost before the input register");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready && valid_s1 |=> valid_s1)
		else $error("pending item dropped while result stalled");

endmodule
`default_nettype wire

### rtl/awm_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_ring
// Letter ring of the sliding window. One write port, one registered read
// port; a write to the slot being read is passed straight to the read data.
// ----------------------------------------------------------------------------
module awm_ring #(
	parameter int AW = 5,
	parameter int DW = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/awm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_core
// Pattern and window histograms, window bookkeeping and text position.
// Takes one item per cycle and gives its result in the same cycle.
// ----------------------------------------------------------------------------
module awm_core import awm_pkg::*; #(
	parameter int              MAX_PATTERN = AWM_MAX_PATTERN,
	parameter longint unsigned MAX_TEXT    = AWM_MAX_TEXT,
	parameter int              ALPHABET    = AWM_ALPHABET
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      go,
	input  wire item_t     item,
	output core_res_t      res
);

	localparam int POS_W   = $clog2(MAX_TEXT);
	localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [POS_W:0]       POS_END   = (POS_W+1)'(MAX_TEXT);
	localparam logic [LIM_W-1:0]     ALPHA_LIM = LIM_W'(ALPHABET);
	localparam logic [CNT_W-1:0]     PAT_LIM   = CNT_W'(MAX_PATTERN);

	logic [CNT_W-1:0]   pc_q [ALPHABET];
	logic [CNT_W-1:0]   wc_q [ALPHABET];
	logic [CNT_W-1:0]   plen_q;
	logic [CNT_W-1:0]   fill_q;
	logic [RING_AW-1:0] oldest_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   wstart_q;

	logic [CNT_W-1:0]   pc_d [ALPHABET];
	logic [CNT_W-1:0]   wc_d [ALPHABET];
	logic [CNT_W-1:0]   plen_d;
	logic [CNT_W-1:0]   fill_d;
	logic [RING_AW-1:0] oldest_d;
	logic [POS_W-1:0]   pos_d;
	logic [POS_W-1:0]   wstart_d;

	logic [CNT_W-1:0]    wc_inc [ALPHABET];
	logic [ALPHABET-1:0] hit;
	logic [ALPHABET-1:0] old_hit;
	logic [ALPHABET-1:0] eq;
	logic                in_alpha;
	logic [LETTER_W-1:0] old_letter;
	logic [LETTER_W-1:0] ring_rdata;
	logic [CNT_W-1:0]    fill_inc;
	logic [POS_W-1:0]    pos_inc;
	logic                ring_we;
	logic [RING_AW-1:0]  ring_waddr;

	function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
		logic [POS_W:0] s;
		s = (POS_W+1)'(p) + (POS_W+1)'(1);
		return (s == POS_END) ? '0 : s[POS_W-1:0];
	endfunction

	always_comb begin
		in_alpha   = LIM_W'(item.letter) < ALPHA_LIM;
		old_letter = (fill_q == '0) ? item.letter : ring_rdata;
		fill_inc   = fill_q + CNT_W'(1);
		pos_inc    = next_pos(pos_q);
		ring_waddr = RING_AW'(CNT_W'(oldest_q) + fill_q);
		for (int i = 0; i < ALPHABET; i++) begin
			hit[i]     = LIM_W'(item.letter) == LIM_W'(i);
			old_hit[i] = LIM_W'(old_letter) == LIM_W'(i);
			wc_inc[i]  = wc_q[i] + CNT_W'(hit[i]);
			eq[i]      = wc_inc[i] == pc_q[i];
		end

		pc_d     = pc_q;
		wc_d     = wc_q;
		plen_d   = plen_q;
		fill_d   = fill_q;
		oldest_d = oldest_q;
		pos_d    = pos_q;
		wstart_d = wstart_q;
		ring_we  = 1'b0;
		res      = '0;

		if (go) begin
			case (item.mode)
				MODE_CLEAR: begin
					for (int i = 0; i < ALPHABET; i++) begin
						pc_d[i] = '0;
						wc_d[i] = '0;
					end
					plen_d   = '0;
					fill_d   = '0;
					oldest_d = '0;
					pos_d    = '0;
					wstart_d = '0;
				end
				MODE_PATTERN: begin
					if (in_alpha && (plen_q < PAT_LIM)) begin
						for (int i = 0; i < ALPHABET; i++) begin
							pc_d[i] = pc_q[i] + CNT_W'(hit[i]);
							wc_d[i] = '0;
						end
						plen_d   = plen_q + CNT_W'(1);
						fill_d   = '0;
						oldest_d = '0;
						wstart_d = pos_q;
					end
				end
				MODE_TEXT: begin
					pos_d = pos_inc;
					if (!in_alpha) begin
						for (int i = 0; i < ALPHABET; i++) begin
							wc_d[i] = '0;
						end
						fill_d   = '0;
						oldest_d = '0;
						wstart_d = pos_inc;
					end else if (plen_q == '0) begin
						wstart_d = pos_inc;
					end else begin
						ring_we = 1'b1;
						if (fill_inc >= plen_q) begin
							if (&eq) begin
								res.valid       = 1'b1;
								res.match_start = START_W'(wstart_q);
								for (int i = 0; i < ALPHABET; i++) begin
									wc_d[i] = '0;
								end
								fill_d   = '0;
								oldest_d = '0;
								wstart_d = pos_inc;
							end else begin
								for (int i = 0; i < ALPHABET; i++) begin
									wc_d[i] = wc_inc[i]
										- CNT_W'(old_hit[i] && (wc_inc[i] != '0));
								end
								oldest_d = oldest_q + RING_AW'(1);
								fill_d   = fill_q;
								wstart_d = next_pos(wstart_q);
							end
						end else begin
							wc_d   = wc_inc;
							fill_d = fill_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET; i++) begin
				pc_q[i] <= '0;
				wc_q[i] <= '0;
			end
			plen_q   <= '0;
			fill_q   <= '0;
			oldest_q <= '0;
			pos_q    <= '0;
			wstart_q <= '0;
		end else begin
			pc_q     <= pc_d;
			wc_q     <= wc_d;
			plen_q   <= plen_d;
			fill_q   <= fill_d;
			oldest_q <= oldest_d;
			pos_q    <= pos_d;
			wstart_q <= wstart_d;
		end
	end

	awm_ring #(
		.AW (RING_AW),
		.DW (LETTER_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (item.letter),
		.raddr (oldest_d),
		.rdata (ring_rdata)
	);

endmodule
`default_nettype wire
